>>> rtl/dngr_pkg.sv
// Shared types, constants and the glyph font of the decimal number glyph rasterizer.
// Used by the microcode sequencer and by the top level; depends on nothing else.
package dngr_pkg;

    // Default number of decimal digit slots.
    localparam int MaxDigitsDef = 10;
    // Rows of one glyph, pixels per row and horizontal pitch of a digit.
    localparam int GlyphRows = 5;
    localparam int GlyphW = 3;
    localparam int DigitPitch = 4;

    // Field widths.
    localparam int ValueW = 31;
    localparam int CoordW = 13;
    localparam int AnchorW = 12;
    localparam int MinDigW = 4;
    localparam int AlignW = 2;
    localparam int DigitW = 4;
    localparam int RowW = 3;
    localparam int CfgIdxW = 2;
    localparam int CfgDataW = 12;
    localparam int InDataW = 32;
    localparam int OutDataW = 40;

    // Reciprocal of ten for a 32-bit dividend: q = (v * Recip10) >> Recip10Shift.
    localparam logic [31:0] Recip10 = 32'hCCCC_CCCD;
    localparam int Recip10Shift = 35;

    // Register indexes of the configuration port.
    typedef enum logic [CfgIdxW-1:0] {
        REG_MIN_DIGITS = 2'd0,
        REG_ALIGN_MODE = 2'd1,
        REG_ANCHOR_X   = 2'd2,
        REG_ANCHOR_Y   = 2'd3
    } t_reg_idx;

    // Alignment modes; the unused code behaves as left alignment.
    typedef enum logic [AlignW-1:0] {
        ALIGN_LEFT   = 2'd0,
        ALIGN_RIGHT  = 2'd1,
        ALIGN_CENTER = 2'd2
    } t_align;

    // Datapath operation of one microcode step.
    typedef enum logic [2:0] {
        OP_NOP,
        OP_WAIT,
        OP_MUL,
        OP_DIGIT,
        OP_PAD,
        OP_PLACE,
        OP_EMIT
    } t_op;

    // Jump condition of one microcode step.
    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_INPUT,
        COND_MORE_DIGITS,
        COND_NEED_PAD,
        COND_EMIT_BUSY
    } t_cond;

    localparam int PcW = 3;

    // One control word.
    typedef struct packed {
        t_op            op;
        t_cond          cond;
        logic [PcW-1:0] target;
    } t_uword;

    // Status from the datapath that the jump conditions test.
    typedef struct packed {
        logic in_accept;
        logic more_digits;
        logic need_pad;
        logic emit_busy;
    } t_flags;

    // Program step addresses.
    localparam logic [PcW-1:0] PcIdle  = 3'd0;
    localparam logic [PcW-1:0] PcMul   = 3'd1;
    localparam logic [PcW-1:0] PcDigit = 3'd2;
    localparam logic [PcW-1:0] PcPad   = 3'd3;
    localparam logic [PcW-1:0] PcPlace = 3'd4;
    localparam logic [PcW-1:0] PcEmit  = 3'd5;

    // One row of the 3x5 font, bit 2 is the leftmost pixel.
    function automatic logic [GlyphW-1:0] glyph_row(input logic [DigitW-1:0] digit,
                                                    input logic [RowW-1:0] row);
        logic [GlyphRows*GlyphW-1:0] g;
        logic [GlyphW-1:0] bits;
        case (digit)
            4'd0: g = 15'b111_101_101_101_111;
            4'd1: g = 15'b010_110_010_010_111;
            4'd2: g = 15'b111_001_111_100_111;
            4'd3: g = 15'b111_001_111_001_111;
            4'd4: g = 15'b101_101_111_001_001;
            4'd5: g = 15'b111_100_111_001_111;
            4'd6: g = 15'b111_100_111_101_111;
            4'd7: g = 15'b111_001_001_001_001;
            4'd8: g = 15'b111_101_111_101_111;
            4'd9: g = 15'b111_101_111_001_111;
            default: g = '0;
        endcase
        case (row)
            3'd0: bits = g[14:12];
            3'd1: bits = g[11:9];
            3'd2: bits = g[8:6];
            3'd3: bits = g[5:3];
            3'd4: bits = g[2:0];
            default: bits = '0;
        endcase
        return bits;
    endfunction

endpackage

>>> rtl/dngr_seq.sv
// Microcode sequencer of the glyph rasterizer: step counter and control store.
// Depends on dngr_pkg for the control word, condition and flag types.
module dngr_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  dngr_pkg::t_flags i_flags,
    output dngr_pkg::t_uword o_uword
);
    import dngr_pkg::*;

    logic [PcW-1:0] r_pc;
    logic [PcW-1:0] n_pc;
    logic           jump;

    // Control store: one word per step.
    function automatic t_uword ucode(input logic [PcW-1:0] pc);
        t_uword w;
        case (pc)
            PcIdle:  w = '{op: OP_WAIT,  cond: COND_NO_INPUT,    target: PcIdle};
            PcMul:   w = '{op: OP_MUL,   cond: COND_NEVER,       target: PcIdle};
            PcDigit: w = '{op: OP_DIGIT, cond: COND_MORE_DIGITS, target: PcMul};
            PcPad:   w = '{op: OP_PAD,   cond: COND_NEED_PAD,    target: PcPad};
            PcPlace: w = '{op: OP_PLACE, cond: COND_NEVER,       target: PcIdle};
            PcEmit:  w = '{op: OP_EMIT,  cond: COND_EMIT_BUSY,   target: PcEmit};
            default: w = '{op: OP_NOP,   cond: COND_ALWAYS,      target: PcIdle};
        endcase
        return w;
    endfunction

    assign o_uword = ucode(r_pc);

    // Jump condition select.
    always_comb begin
        case (o_uword.cond)
            COND_NEVER:       jump = 1'b0;
            COND_ALWAYS:      jump = 1'b1;
            COND_NO_INPUT:    jump = !i_flags.in_accept;
            COND_MORE_DIGITS: jump = i_flags.more_digits;
            COND_NEED_PAD:    jump = i_flags.need_pad;
            COND_EMIT_BUSY:   jump = i_flags.emit_busy;
            default:          jump = 1'b0;
        endcase
        n_pc = jump ? o_uword.target : r_pc + 1'b1;
    end

    // Step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PcIdle;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

>>> rtl/decimal_number_glyph_rasterizer.sv
// Top level of the decimal number glyph rasterizer: config registers and datapath.
// Depends on dngr_pkg and on the microcode sequencer dngr_seq.
//
// Usage: each transaction on the input stream carries one non-negative value in
// i_s_axis_tdata[30:0]. The block splits it into decimal digits, pads with leading
// zeros up to min_digits and streams one transaction per glyph row on the output:
// digits most significant first, rows top to bottom, tlast on the bottom row of
// the least significant digit. A value of count digits gives 5*count transactions.
// Sequence: after the input transaction each natural digit takes a multiply step
// (by the reciprocal of ten) and a remainder step, then comes a pad step per pad
// digit and a final pad step that finds no more to pad, a placement step, one row
// per cycle while the receiver does not stall, and a step back to idle. One item
// runs at a time; o_s_axis_tready is high only in the idle step out of reset, which
// may overlap a last row still held on output. Reset restores min_digits 2, right
// alignment and both anchors at zero, and empties the output register. When the
// receiver stalls, the held row stays on the output and the sequencer waits in its
// emit step. Configuration writes take effect at once and must be made while the
// block is idle; the user is bound to this, and the block does not enforce it.
module decimal_number_glyph_rasterizer #(
    parameter int MAX_DIGITS = dngr_pkg::MaxDigitsDef
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration write port.
    input  logic                            i_cfg_we,
    input  logic [dngr_pkg::CfgIdxW-1:0]    i_cfg_idx,
    input  logic [dngr_pkg::CfgDataW-1:0]   i_cfg_data,
    // Input stream; tdata: value[30:0], zero bit 31.
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [dngr_pkg::InDataW-1:0]    i_s_axis_tdata,
    // Output stream; tdata: digit_x[12:0], row_y[25:13], row_bits[28:26],
    // digit_value[32:29], zeros [39:33]; tlast: last_row.
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [dngr_pkg::OutDataW-1:0]   o_m_axis_tdata,
    output logic                            o_m_axis_tlast
);
    import dngr_pkg::*;

    localparam int CntW = $clog2(MAX_DIGITS + 1);
    localparam int IdxW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    // Configuration registers.
    logic [MinDigW-1:0] r_min_digits;
    logic [AlignW-1:0]  r_align_mode;
    logic [AnchorW-1:0] r_anchor_x;
    logic [AnchorW-1:0] r_anchor_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_digits <= MinDigW'(2);
            r_align_mode <= ALIGN_RIGHT;
            r_anchor_x   <= '0;
            r_anchor_y   <= '0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_MIN_DIGITS: r_min_digits <= i_cfg_data[MinDigW-1:0];
                REG_ALIGN_MODE: r_align_mode <= i_cfg_data[AlignW-1:0];
                REG_ANCHOR_X:   r_anchor_x   <= i_cfg_data[AnchorW-1:0];
                REG_ANCHOR_Y:   r_anchor_y   <= i_cfg_data[AnchorW-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer.
    t_uword uword;
    t_flags flags;

    dngr_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_uword (uword)
    );

    // Datapath registers.
    logic [ValueW-1:0]        r_val;
    logic [ValueW-1:0]        r_quo;
    logic [CntW-1:0]          r_count;
    logic [DigitW-1:0]        r_digs [MAX_DIGITS];
    logic [IdxW-1:0]          r_dig_idx;
    logic [RowW-1:0]          r_row;
    logic signed [CoordW-1:0] r_x;

    logic                     r_out_valid;
    logic signed [CoordW-1:0] r_out_x;
    logic [CoordW-1:0]        r_out_y;
    logic [GlyphW-1:0]        r_out_bits;
    logic [DigitW-1:0]        r_out_digit;
    logic                     r_out_last;

    // Combinational helpers.
    logic                     in_acc;
    logic [2*ValueW:0]        prod;
    logic [DigitW-1:0]        rem;
    logic [CntW-1:0]          cnt_inc;
    logic [MinDigW-1:0]       want;
    logic signed [CoordW-1:0] text_w;
    logic signed [CoordW-1:0] ax;
    logic signed [CoordW-1:0] diff;
    logic signed [CoordW-1:0] x0;
    logic                     out_load;
    logic                     row_last;
    logic                     item_last;
    logic [DigitW-1:0]        cur_digit;

    // Input is taken only in the idle step and never while reset is held.
    assign o_s_axis_tready = (uword.op == OP_WAIT) && i_rst_n;
    assign in_acc = o_s_axis_tready && i_s_axis_tvalid;

    // Division by ten: quotient registered, remainder from the quotient.
    assign prod    = (2*ValueW+1)'(r_val) * (2*ValueW+1)'(Recip10);
    assign rem     = DigitW'(r_val - (r_quo << 3) - (r_quo << 1));
    assign cnt_inc = r_count + 1'b1;

    // Digit count target, saturated at the number of digit slots.
    assign want = (r_min_digits > MinDigW'(MAX_DIGITS)) ? MinDigW'(MAX_DIGITS)
                                                         : r_min_digits;

    // Start x of the text for the configured alignment.
    always_comb begin
        text_w = CoordW'(r_count) * CoordW'(DigitPitch) - CoordW'(1);
        ax     = CoordW'(r_anchor_x);
        diff   = ax - text_w;
        case (t_align'(r_align_mode))
            ALIGN_RIGHT:  x0 = ax - CoordW'(1) - text_w;
            // Halving that truncates toward zero.
            ALIGN_CENTER: x0 = $signed(diff + CoordW'(diff[CoordW-1])) >>> 1;
            default:      x0 = ax;
        endcase
    end

    // Row emission control.
    assign out_load  = (uword.op == OP_EMIT) && (!r_out_valid || i_m_axis_tready);
    assign row_last  = (r_row == RowW'(GlyphRows - 1));
    assign item_last = row_last && (r_dig_idx == '0);
    assign cur_digit = r_digs[r_dig_idx];

    // Status for the jump conditions.
    always_comb begin
        flags.in_accept   = in_acc;
        flags.more_digits = (r_quo != '0) && (cnt_inc < CntW'(MAX_DIGITS));
        flags.need_pad    = (MinDigW'(r_count) < want);
        flags.emit_busy   = !(out_load && item_last);
    end

    // Datapath steps.
    always_ff @(posedge i_clk) begin
        case (uword.op)
            OP_WAIT: begin
                r_val   <= i_s_axis_tdata[ValueW-1:0];
                r_count <= '0;
            end
            OP_MUL: begin
                r_quo <= ValueW'(prod[2*ValueW:Recip10Shift]);
            end
            OP_DIGIT: begin
                r_digs[r_count[IdxW-1:0]] <= rem;
                r_count                   <= cnt_inc;
                r_val                     <= r_quo;
            end
            OP_PAD: begin
                if (flags.need_pad) begin
                    r_digs[r_count[IdxW-1:0]] <= '0;
                    r_count                   <= cnt_inc;
                end
            end
            OP_PLACE: begin
                r_dig_idx <= IdxW'(r_count - 1'b1);
                r_row     <= '0;
                r_x       <= x0;
            end
            OP_EMIT: begin
                if (out_load) begin
                    if (row_last) begin
                        r_row     <= '0;
                        r_dig_idx <= r_dig_idx - 1'b1;
                        r_x       <= r_x + CoordW'(DigitPitch);
                    end else begin
                        r_row <= r_row + 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_x     <= r_x;
            r_out_y     <= CoordW'(r_anchor_y) + CoordW'(r_row);
            r_out_bits  <= glyph_row(cur_digit, r_row);
            r_out_digit <= cur_digit;
            r_out_last  <= item_last;
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {(OutDataW - 2*CoordW - GlyphW - DigitW)'(0),
                              r_out_digit, r_out_bits, r_out_y, r_out_x};
    assign o_m_axis_tlast  = r_out_last;

endmodule

>>> dv/decimal_number_glyph_rasterizer_tb.sv
// Self-checking testbench of the decimal number glyph rasterizer.
// It drives values and register settings, predicts every glyph row and checks the output stream.
// Depends on dngr_pkg and on the top level decimal_number_glyph_rasterizer.
`timescale 1ns / 1ps

module decimal_number_glyph_rasterizer_tb;

    import dngr_pkg::*;

    localparam int MaxDigits = MaxDigitsDef;
    localparam int MaxValue = 2147483647;
    localparam int SendTimeoutNs = 10_000_000;
    localparam int TailCycles = 100;
    localparam int RandomPhases = 8;
    localparam int ValuesPerPhase = 19;
    // The alignment code with no enum member behaves as left alignment.
    localparam logic [AlignW-1:0] AlignSpare = 2'd3;

    // Font rows from top to bottom, three pixels each, leftmost pixel in the high bit.
    localparam logic [GlyphRows*GlyphW-1:0] Font [10] = '{
        15'b111_101_101_101_111, 15'b010_110_010_010_111, 15'b111_001_111_100_111,
        15'b111_001_111_001_111, 15'b101_101_111_001_001, 15'b111_100_111_001_111,
        15'b111_100_111_101_111, 15'b111_001_001_001_001, 15'b111_101_111_101_111,
        15'b111_101_111_001_111
    };

    // One glyph row as it should leave the block.
    typedef struct {
        logic [CoordW-1:0] digit_x;
        logic [CoordW-1:0] row_y;
        logic [RowW-1:0]   row_bits;
        logic [DigitW-1:0] digit_value;
        logic              last_row;
    } glyph_row_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CfgIdxW-1:0]    i_cfg_idx = '0;
    logic [CfgDataW-1:0]   i_cfg_data = '0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [InDataW-1:0]    i_s_axis_tdata = '0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [OutDataW-1:0]   o_m_axis_tdata;
    logic                  o_m_axis_tlast;

    // Register copies used by the row predictor.
    logic [MinDigW-1:0]    cfg_min_digits = 4'd2;
    logic [AlignW-1:0]     cfg_align = ALIGN_RIGHT;
    logic [AnchorW-1:0]    cfg_anchor_x = '0;
    logic [AnchorW-1:0]    cfg_anchor_y = '0;

    logic [ValueW-1:0]     values_to_send[$];
    glyph_row_t            pending_rows[$];
    bit                    sender_idles = 1'b1;
    bit                    receiver_idles = 1'b1;
    int                    send_gap = 0;
    int                    send_gap_draw;
    int                    recv_stall = 0;
    int                    recv_stall_draw;
    int                    error_count = 0;
    int                    values_sent = 0;
    int                    rows_checked = 0;
    int                    settings_used = 0;

    decimal_number_glyph_rasterizer DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),  // value[30:0], zero bit 31
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),  // digit_x, row_y, row_bits, digit_value, zeros
        .o_m_axis_tlast (o_m_axis_tlast)   // last_row
    );

    // Clock and the single reset at the start of the run.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Watchdog against a hung handshake.
    initial begin
        #(SendTimeoutNs);
        $display("decimal_number_glyph_rasterizer_tb: FAIL");
        $finish;
    end

    function automatic int draw_wait(input bit enabled);
        return enabled ? int'($urandom_range(0, 13)) : 0;
    endfunction

    // Computes the rows of one value from the current register copies.
    task automatic rasterize_value(input logic [ValueW-1:0] value);
        int unsigned rest;
        int          digits[MaxDigits];
        int          count;
        int          wanted;
        int          text_width;
        int          start_x;
        int          x;
        int          shift;
        glyph_row_t  row;
        rest = value;
        count = 0;
        do begin
            digits[count] = rest % 10;
            rest = rest / 10;
            count++;
        end while (rest > 0 && count < MaxDigits);
        // A zero minimum still shows the one natural digit; large minimums saturate.
        wanted = (cfg_min_digits > MaxDigits) ? MaxDigits : int'(cfg_min_digits);
        while (count < wanted) begin
            digits[count] = 0;
            count++;
        end
        text_width = count * DigitPitch - 1;
        if (cfg_align == ALIGN_RIGHT) begin
            start_x = int'(cfg_anchor_x) - 1 - text_width;
        end else if (cfg_align == ALIGN_CENTER) begin
            // Signed division truncates toward zero.
            start_x = (int'(cfg_anchor_x) - text_width) / 2;
        end else begin
            start_x = int'(cfg_anchor_x);
        end
        for (int i = count - 1; i >= 0; i--) begin
            x = start_x + (count - 1 - i) * DigitPitch;
            for (int r = 0; r < GlyphRows; r++) begin
                shift = (GlyphRows - 1 - r) * GlyphW;
                row.digit_x = x[CoordW-1:0];
                row.row_y = CoordW'(cfg_anchor_y) + CoordW'(r);
                row.row_bits = RowW'(Font[digits[i]] >> shift);
                row.digit_value = DigitW'(digits[i]);
                row.last_row = (i == 0 && r == GlyphRows - 1);
                pending_rows = {pending_rows, row};
            end
        end
    endtask

    task automatic report_mismatch(input string msg);
        if (error_count < 40) begin
            $display("ERROR at %0t: %s", $realtime, msg);
        end
        error_count++;
    endtask

    // Compares one output transaction with the oldest pending row.
    task automatic check_row(input logic [OutDataW-1:0] data, input logic last);
        glyph_row_t want;
        if (pending_rows.size() == 0) begin
            report_mismatch($sformatf("row %0d arrived with none pending", rows_checked));
        end else begin
            want = pending_rows.pop_front();
            if (data[12:0] !== want.digit_x)
                report_mismatch($sformatf("row %0d digit_x got %0d expected %0d",
                                          rows_checked, $signed(data[12:0]),
                                          $signed(want.digit_x)));
            if (data[25:13] !== want.row_y)
                report_mismatch($sformatf("row %0d row_y got %0d expected %0d",
                                          rows_checked, data[25:13], want.row_y));
            if (data[28:26] !== want.row_bits)
                report_mismatch($sformatf("row %0d row_bits got %b expected %b",
                                          rows_checked, data[28:26], want.row_bits));
            if (data[32:29] !== want.digit_value)
                report_mismatch($sformatf("row %0d digit_value got %0d expected %0d",
                                          rows_checked, data[32:29], want.digit_value));
            if (last !== want.last_row)
                report_mismatch($sformatf("row %0d last_row got %b expected %b",
                                          rows_checked, last, want.last_row));
            if (data[OutDataW-1:33] !== '0)
                report_mismatch($sformatf("row %0d padding bits got %b",
                                          rows_checked, data[OutDataW-1:33]));
        end
        rows_checked++;
    endtask

    // Value sender: one value per transaction, with a random gap after each while the sender idles.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            send_gap <= 0;
        end else if (i_s_axis_tvalid && o_s_axis_tready) begin
            send_gap_draw = draw_wait(sender_idles);
            if (send_gap_draw == 0 && values_to_send.size() != 0) begin
                i_s_axis_tdata <= {1'b0, values_to_send.pop_front()};
            end else begin
                i_s_axis_tvalid <= 1'b0;
                send_gap <= (send_gap_draw > 0) ? send_gap_draw - 1 : 0;
            end
        end else if (!i_s_axis_tvalid) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
            end else if (values_to_send.size() != 0) begin
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata <= {1'b0, values_to_send.pop_front()};
            end
        end
    end

    // Row receiver: after each transaction it may drop tready for a random stall while the receiver idles.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b1;
            recv_stall <= 0;
        end else if (o_m_axis_tvalid && i_m_axis_tready) begin
            recv_stall_draw = draw_wait(receiver_idles);
            if (recv_stall_draw != 0) begin
                i_m_axis_tready <= 1'b0;
                recv_stall <= recv_stall_draw;
            end
        end else if (!i_m_axis_tready) begin
            if (recv_stall <= 1) begin
                i_m_axis_tready <= 1'b1;
            end
            recv_stall <= recv_stall - 1;
        end
    end

    // Monitor: checks rows first, then predicts rows of a newly accepted value.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                check_row(o_m_axis_tdata, o_m_axis_tlast);
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                rasterize_value(i_s_axis_tdata[ValueW-1:0]);
                values_sent++;
            end
        end
    end

    // Writes all four registers on consecutive edges; only called while idle.
    task automatic apply_config(input logic [MinDigW-1:0] min_digits,
                                input logic [AlignW-1:0] align,
                                input logic [AnchorW-1:0] anchor_x,
                                input logic [AnchorW-1:0] anchor_y);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= REG_MIN_DIGITS;
        i_cfg_data <= CfgDataW'(min_digits);
        @(posedge i_clk);
        i_cfg_idx <= REG_ALIGN_MODE;
        i_cfg_data <= CfgDataW'(align);
        @(posedge i_clk);
        i_cfg_idx <= REG_ANCHOR_X;
        i_cfg_data <= anchor_x;
        @(posedge i_clk);
        i_cfg_idx <= REG_ANCHOR_Y;
        i_cfg_data <= anchor_y;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_min_digits = min_digits;
        cfg_align = align;
        cfg_anchor_x = anchor_x;
        cfg_anchor_y = anchor_y;
        settings_used++;
    endtask

    // Waits until every queued value has gone in and every row has come out.
    task automatic drain();
        @(negedge i_clk);
        while (values_to_send.size() != 0 || i_s_axis_tvalid || pending_rows.size() != 0)
            @(negedge i_clk);
    endtask

    // Random value with a uniformly drawn digit count, or a raw 31-bit pattern.
    function automatic logic [ValueW-1:0] random_value();
        int    ndig;
        longint lo;
        longint hi;
        ndig = $urandom_range(1, MaxDigits + 1);
        if (ndig > MaxDigits) begin
            return ValueW'($urandom);
        end
        lo = 1;
        repeat (ndig - 1) lo = lo * 10;
        hi = lo * 10 - 1;
        if (ndig == 1) lo = 0;
        if (hi > MaxValue) hi = MaxValue;
        return ValueW'(lo + longint'($urandom) % (hi - lo + 1));
    endfunction

    function automatic logic [AnchorW-1:0] random_anchor();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return AnchorW'($urandom_range(0, 60));
            default: return AnchorW'($urandom);
        endcase
    endfunction

    // Stimulus: directed values and settings first, then random phases.
    initial begin
        @(posedge i_rst_n);

        // Reset settings: two digits, right aligned at zero, so x goes negative.
        @(negedge i_clk);
        settings_used++;
        values_to_send = '{31'd0, 31'd7, 31'd42, 31'd1234567890, 31'(MaxValue),
                           31'd1000000000, 31'd999999999, 31'd1073741824, 31'd10,
                           31'd99, 31'd100};
        drain();

        // Zero minimum with the spare alignment code and both anchors at their top.
        apply_config(4'd0, AlignSpare, '1, '1);
        @(negedge i_clk);
        values_to_send = '{31'd0, 31'd5, 31'd31};
        drain();

        // Saturating minimum, centered at zero: truncation toward zero on a negative x.
        apply_config('1, ALIGN_CENTER, '0, '0);
        @(negedge i_clk);
        values_to_send = '{31'd8, 31'(MaxValue)};
        drain();

        apply_config(4'd10, ALIGN_RIGHT, '1, '1);
        @(negedge i_clk);
        values_to_send = '{31'd6, 31'd4000, 31'd3};
        drain();

        apply_config(4'd1, ALIGN_CENTER, 12'd1, '0);
        @(negedge i_clk);
        values_to_send = '{31'd0, 31'd46};
        drain();

        apply_config(4'd1, ALIGN_LEFT, '0, '1);
        @(negedge i_clk);
        values_to_send = '{31'd9};
        drain();

        // Random phases; some run with one or both sides never idling.
        for (int p = 0; p < RandomPhases; p++) begin
            apply_config(MinDigW'($urandom_range(0, 15)), AlignW'($urandom_range(0, 3)),
                         random_anchor(), random_anchor());
            @(negedge i_clk);
            sender_idles = ($urandom_range(0, 3) != 0);
            receiver_idles = ($urandom_range(0, 3) != 0);
            for (int n = 0; n < ValuesPerPhase; n++)
                values_to_send = {values_to_send, random_value()};
            drain();
        end

        repeat (TailCycles) @(posedge i_clk);
        if (pending_rows.size() != 0) begin
            report_mismatch($sformatf("%0d rows never arrived", pending_rows.size()));
        end
        $display("Run covered %0d values and %0d glyph rows over %0d register settings.",
                 values_sent, rows_checked, settings_used);
        $display("Mismatches found: %0d.", error_count);
        if (error_count == 0) begin
            $display("decimal_number_glyph_rasterizer_tb: PASS");
        end else begin
            $display("decimal_number_glyph_rasterizer_tb: FAIL");
        end
        $finish;
    end

endmodule
